FILE: rtl/dsh_pkg.sv
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared widths, register codes and helpers of the wrapping terrain generator.
// ----------------------------------------------------------------------------
package dsh_pkg;

  localparam int MAX_LEVELS_DEF = 8;
  localparam int SAMPLE_W       = 16;
  localparam int HEIGHT_W       = 32;
  localparam int SCALE_W        = 31;
  localparam int RATIO_W        = 16;
  localparam int COUNT_W        = 4;
  localparam int GRID_W         = 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int OUT_DATA_W     = 2 * GRID_W + HEIGHT_W;
  localparam int SUM_W          = HEIGHT_W + 3;
  localparam int PROD_W         = SCALE_W + 1 + SAMPLE_W;

  localparam logic [SCALE_W-1:0] INIT_SCALE_RST = SCALE_W'(65536);
  localparam logic [RATIO_W-1:0] RATIO_RST      = RATIO_W'(32768);
  localparam logic [COUNT_W-1:0] COUNT_RST      = COUNT_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_SCALE  = 2'd0,
    CFG_LEVEL_RATIO = 2'd1,
    CFG_LEVEL_COUNT = 2'd2
  } cfg_reg_t;

  // queue entry: row, column, four neighbour addresses, scale, sample, last
  function automatic int item_width(input int levels);
    return 2 * levels + 4 * (2 * levels) + SCALE_W + SAMPLE_W + 1;
  endfunction

endpackage

FILE: rtl/dsh_front.sv
// ----------------------------------------------------------------------------
// dsh_front
// Configuration registers and point traversal; emits one work entry per beat.
// ----------------------------------------------------------------------------
module dsh_front import dsh_pkg::*; #(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF,
  localparam int CW = MAX_LEVELS + 1,
  localparam int AW = 2 * MAX_LEVELS,
  localparam int IW = item_width(MAX_LEVELS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,
  output logic                  push_o,
  output logic [IW-1:0]         item_o,
  input  logic                  full_i
);

  typedef struct packed {
    logic [MAX_LEVELS-1:0]       row;
    logic [MAX_LEVELS-1:0]       col;
    logic [3:0][AW-1:0]          nb;
    logic [SCALE_W-1:0]          scale;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        last;
  } item_t;

  logic [SCALE_W-1:0] init_scale_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [COUNT_W-1:0] count_r;

  logic               act_r, act_nxt;
  logic [CW-1:0]      side_r, side_nxt;
  logic [CW-1:0]      s_r, s_nxt;
  logic [CW-1:0]      r_r, r_nxt;
  logic [CW-1:0]      c_r, c_nxt;
  logic               sq_r, sq_nxt;
  logic               odd_r, odd_nxt;
  logic [SCALE_W-1:0] scale_r, scale_nxt;

  logic [COUNT_W-1:0] lc;
  logic [CW-1:0]      side_st, cur_side, cur_s, cur_r, cur_c;
  logic               cur_sq, cur_odd;
  logic [SCALE_W-1:0] cur_scale;
  logic [CW-1:0]      up, down, left, right, col2, row2, rows;
  logic [SCALE_W+RATIO_W-1:0] sprod;
  logic               last;
  logic               accept;
  item_t              item;

  function automatic logic [MAX_LEVELS-1:0] fold(input logic [CW-1:0] x,
                                                 input logic [CW-1:0] sd);
    return (x == sd) ? '0 : x[MAX_LEVELS-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_tready = !full_i;
  assign accept    = in_tvalid && !full_i;
  assign push_o    = accept;
  assign item_o    = item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_scale_r <= INIT_SCALE_RST;
      ratio_r      <= RATIO_RST;
      count_r      <= COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INIT_SCALE:  init_scale_r <= cfg_data[SCALE_W-1:0];
        CFG_LEVEL_RATIO: ratio_r      <= cfg_data[RATIO_W-1:0];
        CFG_LEVEL_COUNT: count_r      <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (count_r == '0)                          lc = COUNT_W'(1);
    else if (count_r > COUNT_W'(MAX_LEVELS))    lc = COUNT_W'(MAX_LEVELS);
    else                                        lc = count_r;
    side_st   = CW'(1) << lc;
    cur_side  = act_r ? side_r : side_st;
    cur_s     = act_r ? s_r : (side_st >> 1);
    cur_r     = act_r ? r_r : (side_st >> 1);
    cur_c     = act_r ? c_r : (side_st >> 1);
    cur_sq    = act_r && sq_r;
    cur_odd   = act_r && odd_r;
    cur_scale = act_r ? scale_r : init_scale_r;

    up    = (cur_sq && cur_r == '0) ? cur_side - cur_s : cur_r - cur_s;
    left  = (cur_sq && cur_c == '0) ? cur_side - cur_s : cur_c - cur_s;
    down  = cur_r + cur_s;
    right = cur_c + cur_s;

    item.row    = cur_r[MAX_LEVELS-1:0];
    item.col    = cur_c[MAX_LEVELS-1:0];
    item.scale  = cur_scale;
    item.sample = in_tdata;
    if (!cur_sq) begin
      item.nb[0] = {fold(up, cur_side),   fold(left, cur_side)};
      item.nb[1] = {fold(up, cur_side),   fold(right, cur_side)};
      item.nb[2] = {fold(down, cur_side), fold(left, cur_side)};
      item.nb[3] = {fold(down, cur_side), fold(right, cur_side)};
    end else begin
      item.nb[0] = {fold(up, cur_side),    fold(cur_c, cur_side)};
      item.nb[1] = {fold(down, cur_side),  fold(cur_c, cur_side)};
      item.nb[2] = {fold(cur_r, cur_side), fold(left, cur_side)};
      item.nb[3] = {fold(cur_r, cur_side), fold(right, cur_side)};
    end

    sprod = cur_scale * ratio_r + (SCALE_W+RATIO_W)'(32768);
    col2  = cur_c + (cur_s << 1);
    row2  = cur_r + (cur_s << 1);
    rows  = cur_r + cur_s;

    act_nxt   = 1'b1;
    side_nxt  = cur_side;
    s_nxt     = cur_s;
    r_nxt     = cur_r;
    c_nxt     = col2;
    sq_nxt    = cur_sq;
    odd_nxt   = cur_odd;
    scale_nxt = cur_scale;
    last      = 1'b0;
    if (!cur_sq) begin
      if (col2 >= cur_side) begin
        c_nxt = cur_s;
        r_nxt = row2;
        if (row2 >= cur_side) begin
          sq_nxt  = 1'b1;
          r_nxt   = '0;
          c_nxt   = cur_s;
          odd_nxt = 1'b0;
        end
      end
    end else if (col2 >= cur_side) begin
      odd_nxt = !cur_odd;
      if (rows >= cur_side) begin
        scale_nxt = sprod[RATIO_W +: SCALE_W];
        s_nxt     = cur_s >> 1;
        sq_nxt    = 1'b0;
        odd_nxt   = 1'b0;
        if ((cur_s >> 1) == '0) begin
          act_nxt = 1'b0;
          last    = 1'b1;
          r_nxt   = '0;
          c_nxt   = '0;
        end else begin
          r_nxt = cur_s >> 1;
          c_nxt = cur_s >> 1;
        end
      end else begin
        r_nxt = rows;
        c_nxt = !cur_odd ? '0 : cur_s;
      end
    end
    item.last = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      sq_r  <= 1'b0;
      odd_r <= 1'b0;
    end else if (accept) begin
      act_r <= act_nxt;
      sq_r  <= sq_nxt;
      odd_r <= odd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      side_r  <= side_nxt;
      s_r     <= s_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      scale_r <= scale_nxt;
    end
  end

endmodule

FILE: rtl/dsh_queue.sv
// ----------------------------------------------------------------------------
// dsh_queue
// Two-entry queue between traversal and grid arithmetic.
// ----------------------------------------------------------------------------
module dsh_queue import dsh_pkg::*; #(
  parameter int W = item_width(MAX_LEVELS_DEF)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         vld_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] ent_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full_o = (cnt_r == 2'd2);
  assign vld_o  = (cnt_r != 2'd0);
  assign data_o = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_i) wp_r <= !wp_r;
      if (pop_i)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) ent_r[wp_r] <= data_i;
  end

endmodule

FILE: rtl/dsh_back.sv
// ----------------------------------------------------------------------------
// dsh_back
// Grid memory, four neighbour reads per point, average, displacement, output.
// ----------------------------------------------------------------------------
module dsh_back import dsh_pkg::*; #(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF,
  localparam int AW = 2 * MAX_LEVELS,
  localparam int IW = item_width(MAX_LEVELS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  vld_i,
  input  logic [IW-1:0]         item_i,
  output logic                  pop_o,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  typedef struct packed {
    logic [MAX_LEVELS-1:0]       row;
    logic [MAX_LEVELS-1:0]       col;
    logic [3:0][AW-1:0]          nb;
    logic [SCALE_W-1:0]          scale;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        last;
  } item_t;

  logic [HEIGHT_W-1:0] grid_mem [2**AW];

  item_t                     itm_r, q_item;
  logic                      act_r;
  logic [1:0]                ph_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      rd_pend_r, rd_first_r;
  logic [AW-1:0]             rd_addr_r;
  logic [HEIGHT_W-1:0]       rdata_r;
  logic signed [SUM_W-1:0]   acc_r;
  logic                      fin_vld_r;
  logic [MAX_LEVELS-1:0]     fin_row_r, fin_col_r;
  logic                      fin_last_r;
  logic signed [PROD_W-1:0]  fin_prod_r;
  logic                      wb_vld_r;
  logic [AW-1:0]             wb_addr_r;
  logic [HEIGHT_W-1:0]       wb_data_r;
  logic                      out_vld_r;
  logic [OUT_DATA_W-1:0]     out_data_r;
  logic                      out_last_r;

  logic                      adv, pop, rd_en, fin_fire;
  logic [AW-1:0]             rd_addr;
  logic [HEIGHT_W-1:0]       byp;
  logic signed [SUM_W-1:0]   sum;
  logic signed [PROD_W-1:0]  dsum;
  logic signed [HEIGHT_W+1:0] h;
  logic signed [HEIGHT_W-1:0] hsat;

  assign q_item   = item_t'(item_i);
  assign adv      = !(fin_vld_r && out_vld_r && !out_tready);
  assign pop      = adv && vld_i && (!act_r || ph_r == 2'd3);
  assign pop_o    = pop;
  assign rd_en    = adv && act_r;
  assign rd_addr  = itm_r.nb[ph_r];
  assign fin_fire = adv && fin_vld_r;

  // corner cell reads as zero; latest write forwarded
  always_comb begin
    if (rd_addr_r == '0)                            byp = '0;
    else if (wb_vld_r && wb_addr_r == rd_addr_r)    byp = wb_data_r;
    else                                            byp = rdata_r;
    sum  = acc_r + SUM_W'(signed'(byp));
    dsum = fin_prod_r + PROD_W'(32768);
    h    = (HEIGHT_W+2)'(sum >>> 2) + (HEIGHT_W+2)'(dsum >>> 16);
    if (h > (HEIGHT_W+2)'(signed'({1'b0, {(HEIGHT_W-1){1'b1}}})))
      hsat = {1'b0, {(HEIGHT_W-1){1'b1}}};
    else if (h < (HEIGHT_W+2)'(signed'({1'b1, {(HEIGHT_W-1){1'b0}}})))
      hsat = {1'b1, {(HEIGHT_W-1){1'b0}}};
    else
      hsat = h[HEIGHT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= grid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (fin_fire) grid_mem[{fin_row_r, fin_col_r}] <= hsat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r      <= 1'b0;
      ph_r       <= 2'd0;
      rd_pend_r  <= 1'b0;
      fin_vld_r  <= 1'b0;
      wb_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (adv) begin
        if (act_r) ph_r <= ph_r + 2'd1;
        if (!act_r || ph_r == 2'd3) act_r <= pop;
        rd_pend_r <= act_r;
        fin_vld_r <= act_r && ph_r == 2'd3;
      end
      if (fin_fire) wb_vld_r <= 1'b1;
      if (fin_fire)        out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) itm_r <= q_item;
    if (adv) begin
      if (act_r && ph_r == 2'd0)
        prod_r <= signed'({1'b0, itm_r.scale}) * itm_r.sample;
      if (act_r) begin
        rd_addr_r  <= rd_addr;
        rd_first_r <= (ph_r == 2'd0);
      end
      if (rd_pend_r) acc_r <= (rd_first_r ? SUM_W'(2) : acc_r) + SUM_W'(signed'(byp));
      if (act_r && ph_r == 2'd3) begin
        fin_row_r  <= itm_r.row;
        fin_col_r  <= itm_r.col;
        fin_last_r <= itm_r.last;
        fin_prod_r <= prod_r;
      end
    end
    if (fin_fire) begin
      wb_addr_r  <= {fin_row_r, fin_col_r};
      wb_data_r  <= hsat;
      out_data_r <= {hsat, GRID_W'(fin_col_r), GRID_W'(fin_row_r)};
      out_last_r <= fin_last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/diamond_square_heightmap_top.sv
// ----------------------------------------------------------------------------
// diamond_square_heightmap_top
// Wrapping diamond-square height map generator, one point per input sample.
// ----------------------------------------------------------------------------
// Each accepted random sample yields one height point; the first sample with
// no map in progress starts a new map from the registers. A point occupies the
// back end for its four neighbour reads through the single read port of the
// grid memory; the next point's reads follow unless the output stalls. The
// grid memory (2^(2*MAX_LEVELS) words) needs no clearing pass after reset.
module diamond_square_heightmap_top import dsh_pkg::*; #(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // random_sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // grid_row, grid_column, height_value
  output logic                  out_tlast   // last_point
);

  localparam int IW = item_width(MAX_LEVELS);

  logic          push, full, pop, qvld;
  logic [IW-1:0] push_item, head_item;

  dsh_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata,
    .push_o(push), .item_o(push_item), .full_i(full)
  );

  dsh_queue #(.W(IW)) u_queue (
    .clk, .rst_n,
    .push_i(push), .data_i(push_item), .full_o(full),
    .pop_i(pop), .vld_o(qvld), .data_o(head_item)
  );

  dsh_back #(.MAX_LEVELS(MAX_LEVELS)) u_back (
    .clk, .rst_n,
    .vld_i(qvld), .item_i(head_item), .pop_o(pop),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

FILE: rtl/dsh_checker.sv
// ----------------------------------------------------------------------------
// dsh_checker
// Port-level checks of the height map generator.
// ----------------------------------------------------------------------------
module dsh_checker import dsh_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result beat changed");

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  // final point of a map sits on an odd row and an even column
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[0] == 1'b1 && out_tdata[8] == 1'b0)
    else $error("last point off its expected place");

endmodule

bind diamond_square_heightmap_top dsh_checker u_dsh_checker (.*);

FILE: bench/diamond_square_heightmap_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// diamond_square_heightmap_top_test
// Self-checking bench for the wrapping diamond-square height map generator.
// ----------------------------------------------------------------------------
// Streams random samples through whole maps at several register settings,
// extremes included, then part of a map, and checks each point (row, column,
// height, last flag) against an in-bench predictor of the grid traversal. Both
// stream sides idle at random; the receiver once holds off for a long stretch.
module diamond_square_heightmap_top_test;
  import dsh_pkg::*;

  typedef struct {
    logic [GRID_W-1:0]          row;
    logic [GRID_W-1:0]          col;
    logic signed [HEIGHT_W-1:0] height;
    logic                       last;
  } grid_point_t;

  class terrain_scoreboard;
    int                 grid [0:256][0:256];
    int unsigned        init_scale = 65536;
    int unsigned        ratio      = 32768;
    int unsigned        count      = 8;
    int unsigned        lscale, stride, row, col, side;
    bit                 square, odd_row, active;
    grid_point_t        pending_points[$];
    int                 errors;

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      unique case (idx)
        CFG_INIT_SCALE:  init_scale = value & 32'h7FFF_FFFF;
        CFG_LEVEL_RATIO: ratio      = value & 32'h0000_FFFF;
        CFG_LEVEL_COUNT: count      = value & 32'h0000_000F;
        default: ;
      endcase
    endfunction

    function longint rd(int unsigned r, int unsigned c);
      if (r > 256) r = 256;
      if (c > 256) c = 256;
      return grid[r][c];
    endfunction

    function bit note_input(logic signed [SAMPLE_W-1:0] smp);
      int unsigned n, up, left;
      longint      sum, avg, disp, h;
      grid_point_t p;
      if (!active) begin
        n = count;
        if (n < 1) n = 1;
        if (n > MAX_LEVELS_DEF) n = MAX_LEVELS_DEF;
        side = 1 << n;
        grid[0][0] = 0; grid[0][side] = 0; grid[side][0] = 0; grid[side][side] = 0;
        lscale = init_scale;
        stride = side >> 1;
        row = stride; col = stride;
        square = 0; odd_row = 0; active = 1;
      end
      if (!square) begin
        sum = rd(row - stride, col - stride) + rd(row - stride, col + stride)
            + rd(row + stride, col - stride) + rd(row + stride, col + stride);
      end else begin
        up   = (row == 0) ? side - stride : row - stride;
        left = (col == 0) ? side - stride : col - stride;
        sum = rd(up, col) + rd(row + stride, col) + rd(row, left) + rd(row, col + stride);
      end
      avg  = (sum + 2) >>> 2;
      disp = (longint'(lscale) * longint'(smp) + 32768) >>> 16;
      h = avg + disp;
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      grid[row][col] = int'(h);
      if (square) begin
        if (row == 0) grid[side][col] = int'(h);
        if (col == 0) grid[row][side] = int'(h);
      end
      p.row = row[7:0];
      p.col = col[7:0];
      p.height = h[31:0];
      p.last = 1'b0;
      col = col + 2 * stride;
      if (!square) begin
        if (col >= side) begin
          col = stride;
          row = row + 2 * stride;
          if (row >= side) begin
            square = 1; row = 0; col = stride; odd_row = 0;
          end
        end
      end else if (col >= side) begin
        row = row + stride;
        odd_row = !odd_row;
        if (row >= side) begin
          lscale = 32'((longint'(lscale) * ratio + 32768) >> 16);
          stride = stride >> 1;
          square = 0; odd_row = 0;
          if (stride == 0) begin
            active = 0; p.last = 1'b1; row = 0; col = 0;
          end else begin
            row = stride; col = stride;
          end
        end else begin
          col = odd_row ? 0 : stride;
        end
      end
      pending_points.push_back(p);
      return p.last;
    endfunction

    function void check(logic [OUT_DATA_W-1:0] data, logic last);
      grid_point_t e;
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point, actual %h last %b", $time, data, last);
        errors++;
        return;
      end
      e = pending_points.pop_front();
      if (data[7:0] !== e.row) begin
        $display("%0t: row expected %0d actual %0d", $time, e.row, data[7:0]);
        errors++;
      end
      if (data[15:8] !== e.col) begin
        $display("%0t: column expected %0d actual %0d", $time, e.col, data[15:8]);
        errors++;
      end
      if (data[47:16] !== e.height) begin
        $display("%0t: height expected %h actual %h", $time, e.height, data[47:16]);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_points.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_INIT_SCALE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  terrain_scoreboard sb = new();
  int  cycles;
  int  sent;
  bit  in_quiet;
  bit  hold_req;
  int  hold_left;

  diamond_square_heightmap_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tlast);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (in_quiet) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 9);
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic configure(int unsigned scale, int unsigned ratio, int unsigned count);
    drain();
    write_reg(CFG_INIT_SCALE, scale);
    write_reg(CFG_LEVEL_RATIO, ratio);
    write_reg(CFG_LEVEL_COUNT, count);
  endtask

  // hold valid high across back-to-back beats; drop only on an idle cycle
  task automatic send_sample(logic [SAMPLE_W-1:0] smp, output bit last);
    while (!in_quiet && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    last = sb.note_input(smp);
    sent++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_map(int mode);
    bit last;
    int k;
    k = 0;
    do begin
      case (mode)
        1: send_sample(k[0] ? 16'h8000 : 16'h7FFF, last);
        2: send_sample(16'h8000, last);
        default: send_sample(pick_sample(), last);
      endcase
      k++;
    end while (!last);
  endtask

  initial begin
    int unsigned scale, ratio, count;
    bit last;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(65536, 32768, 0);
    run_map(1);
    configure(32'h7FFF_FFFF, 65535, 1);
    run_map(2);
    configure(32'h7FFF_FFFF, 65535, 2);
    run_map(1);
    configure(0, 0, 2);
    run_map(0);

    configure(40000, 50000, 4);
    hold_req = 1'b1;
    run_map(0);

    in_quiet = 1'b1;
    configure(1 << 20, 65535, 3);
    run_map(0);
    in_quiet = 1'b0;

    while (sent < 520) begin
      case ($urandom_range(3))
        0: scale = 32'h7FFF_FFFF;
        1: scale = 0;
        default: scale = $urandom_range(32'h7FFF_FFFF);
      endcase
      case ($urandom_range(3))
        0: ratio = 65535;
        1: ratio = 0;
        default: ratio = $urandom_range(65535);
      endcase
      count = $urandom_range(3);
      configure(scale, ratio, count);
      run_map(0);
    end

    configure($urandom_range(32'h7FFF_FFFF), $urandom_range(65535), 15);
    repeat (30) send_sample(pick_sample(), last);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
